/* rtl/assert_macros.svh */
// assertion macros shared by the frame receiver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define LPFR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked outside reset
`define LPFR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LPFR_ASSERT_IMP(label, clk, rst, ante, cons)
`define LPFR_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/lpfr_pkg.sv */
// shared types and constants of the length-prefixed frame receiver
package lpfr_pkg;

  // receive buffer depth in bytes
  localparam int BUF_SIZE = 1024;
  // position counts 0..BUF_SIZE
  localparam int POS_W = $clog2(BUF_SIZE + 1);

  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 10;
  localparam int LEN_W   = 16;
  localparam int STAT_W  = 2;
  // width for comparing position against the frame length
  localparam int CMP_W   = (POS_W > LEN_W) ? POS_W : LEN_W;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h24;
  localparam logic [POS_W-1:0]  MIN_END_INDEX = POS_W'(4);

  // status codes
  localparam logic [STAT_W-1:0] ST_DROP     = 2'd0;
  localparam logic [STAT_W-1:0] ST_ACCEPT   = 2'd1;
  localparam logic [STAT_W-1:0] ST_LAST     = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

  // one result beat
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [STAT_W-1:0]  status;
    logic [LEN_W-1:0]   frame_length;
  } result_t;

endpackage

/* rtl/lpfr_cfg.sv */
// apb register file holding the sync byte
module lpfr_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [lpfr_pkg::BYTE_W-1:0] sync_byte
);
  import lpfr_pkg::*;

  logic reg_hit;

  // word decode: register 0 at byte address 0
  assign reg_hit = (paddr[2] == 1'b0);
  assign pready  = 1'b1;

  // sync byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= SYNC_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      sync_byte <= pwdata[BYTE_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (reg_hit) begin
      prdata = {{(32-BYTE_W){1'b0}}, sync_byte};
    end
  end

endmodule

/* rtl/lpfr_core.sv */
// frame tracking state and per-byte result logic
`include "assert_macros.svh"

module lpfr_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [lpfr_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [lpfr_pkg::BYTE_W-1:0]   sync_byte,
  output lpfr_pkg::result_t             res
);
  import lpfr_pkg::*;

  logic              in_frame;
  logic [POS_W-1:0]  position;
  logic [LEN_W-1:0]  length_reg;

  logic              in_frame_next;
  logic [POS_W-1:0]  position_next;
  logic [LEN_W-1:0]  length_reg_next;

  logic              buf_full;
  logic              last;
  logic [CMP_W-1:0]  len_minus_one;

  assign buf_full      = (position >= POS_W'(BUF_SIZE));
  assign len_minus_one = CMP_W'(length_reg_next) - CMP_W'(1);

  // length capture from bytes 1 and 2
  always_comb begin
    length_reg_next = length_reg;
    if (in_frame && !buf_full) begin
      if (position == POS_W'(1)) begin
        length_reg_next = {rx_byte, 8'h00};
      end else if (position == POS_W'(2)) begin
        length_reg_next = {length_reg[LEN_W-1:BYTE_W], rx_byte};
      end
    end
  end

  // end of frame check
  assign last = (position >= MIN_END_INDEX) && (length_reg_next != '0) &&
                (CMP_W'(position) >= len_minus_one);

  // next state and result beat
  always_comb begin
    in_frame_next    = in_frame;
    position_next    = position;
    res.out_byte     = rx_byte;
    res.byte_index   = '0;
    res.status       = ST_DROP;
    res.frame_length = length_reg_next;
    if (!in_frame) begin
      position_next = '0;
      if (rx_byte == sync_byte) begin
        in_frame_next = 1'b1;
        position_next = POS_W'(1);
        res.status    = ST_ACCEPT;
      end
    end else if (buf_full) begin
      in_frame_next = 1'b0;
      position_next = '0;
      res.status    = ST_OVERFLOW;
    end else begin
      res.byte_index = position[INDEX_W-1:0];
      if (last) begin
        in_frame_next = 1'b0;
        position_next = '0;
        res.status    = ST_LAST;
      end else begin
        position_next = position + POS_W'(1);
        res.status    = ST_ACCEPT;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      position   <= '0;
      length_reg <= '0;
    end else if (accept) begin
      in_frame   <= in_frame_next;
      position   <= position_next;
      length_reg <= length_reg_next;
    end
  end

  `LPFR_ASSERT_IMP(a_pos_bound, clk, rst, 1'b1, position <= POS_W'(BUF_SIZE))
  `LPFR_ASSERT_IMP(a_hunt_pos, clk, rst, !in_frame, position == '0)
  `LPFR_ASSERT_IMP(a_frame_pos, clk, rst, in_frame, position != '0)
  `LPFR_ASSERT_NXT(a_overflow_hunt, clk, rst, accept && in_frame && buf_full,
                   !in_frame && position == '0)

endmodule

/* rtl/lpfr_outbuf.sv */
// result register with a skid stage
`include "assert_macros.svh"

module lpfr_outbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_accept,
  input  lpfr_pkg::result_t  in_res,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output lpfr_pkg::result_t  out_res
);
  import lpfr_pkg::*;

  logic    skid_full;
  result_t skid_res;
  logic    take;

  assign take     = out_valid && !out_stall;
  assign in_stall = skid_full;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        skid_full <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid && !take) begin
        skid_full <= 1'b1;
      end
      out_valid <= 1'b1;
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (take) begin
        out_res <= skid_res;
      end
    end else if (in_accept) begin
      if (!out_valid || take) begin
        out_res <= in_res;
      end else begin
        skid_res <= in_res;
      end
    end
  end

  `LPFR_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_full, out_valid)
  `LPFR_ASSERT_NXT(a_drain, clk, rst, take && !skid_full && !in_accept, !out_valid)
  `LPFR_ASSERT_NXT(a_skid_fill, clk, rst, in_accept && out_valid && !take, skid_full)

endmodule

/* rtl/length_prefixed_frame_receiver.sv */
// top level of the sync-byte length-prefixed frame receiver
//
// Usage: one received byte per input beat on rx_byte (in_valid/in_stall).
// Every input beat yields exactly one result beat on out_valid/out_stall:
// the echoed byte, its index in the frame, a status code (dropped while
// hunting, accepted, last of frame, overflow) and the captured length.
// A frame opens on a byte equal to the sync register, bytes 1 and 2 carry
// the big-endian total length, and the frame closes at index
// max(4, length - 1); a zero length runs until the buffer size overflows.
// Each result beat is registered; the state update and result register take
// one beat per cycle while in_stall is low. A skid stage lets the input take
// one more beat while a result is held; with the skid full, in_stall rises
// until the receiver drains a beat. Reset (rst, synchronous) returns to
// hunting, clears position and length, empties the result stages and sets
// the sync byte to 0x24. The user writes the sync byte over the APB port at
// address 0 only while idle; the block itself does not enforce this.
module length_prefixed_frame_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [9:0]  byte_index,
  output logic [1:0]  status,
  output logic [15:0] frame_length
);
  import lpfr_pkg::*;

  logic [BYTE_W-1:0] sync_byte;
  logic              accept;
  result_t           core_res;
  result_t           out_res;

  assign accept = in_valid && !in_stall;

  // configuration registers
  lpfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .sync_byte (sync_byte)
  );

  // frame state and result
  lpfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .sync_byte (sync_byte),
    .res       (core_res)
  );

  // output register and skid
  lpfr_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .in_accept (accept),
    .in_res    (core_res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte     = out_res.out_byte;
  assign byte_index   = out_res.byte_index;
  assign status       = out_res.status;
  assign frame_length = out_res.frame_length;

endmodule
